FILE: rtl/rpu_pkg.sv
// ----------------------------------------------------------------------------
// rpu_pkg
// Shared types, constants and helpers for the radial point undistort core.
// ----------------------------------------------------------------------------
package rpu_pkg;

  localparam int RPU_ITERS    = 20;
  localparam int RPU_QBITS    = 32;
  localparam int RPU_DIV_LAT  = RPU_QBITS + 2;
  localparam int RPU_CELL_LAT = 6 + RPU_DIV_LAT;

  localparam logic signed [31:0] Q_MAX   = 32'sh7fff_ffff;
  localparam logic signed [31:0] Q_MIN   = 32'sh8000_0000;
  localparam logic signed [39:0] Q_ONE   = 40'sd268435456;
  localparam logic signed [31:0] RAD_EPS = 32'sd256;
  localparam logic signed [31:0] PIX_MAX = 32'sd2097151;
  localparam logic signed [31:0] PIX_MIN = -32'sd2097152;

  typedef enum logic [2:0] {
    REG_FOCAL_X  = 3'd0,
    REG_FOCAL_Y  = 3'd1,
    REG_CENTER_X = 3'd2,
    REG_CENTER_Y = 3'd3,
    REG_K1       = 3'd4,
    REG_K2       = 3'd5
  } rpu_reg_e;

  typedef struct packed {
    logic               last;
    logic               done;
    logic signed [31:0] xn;
    logic signed [31:0] yn;
    logic signed [31:0] x;
    logic signed [31:0] y;
  } rpu_side_t;

  function automatic logic signed [31:0] rpu_sat32(input logic signed [39:0] v);
    logic signed [31:0] r;
    if (v > 40'(Q_MAX)) r = Q_MAX;
    else if (v < 40'(Q_MIN)) r = Q_MIN;
    else r = v[31:0];
    return r;
  endfunction

endpackage

FILE: rtl/rpu_div.sv
// ----------------------------------------------------------------------------
// rpu_div
// Pipelined restoring divider, two lanes, each with its own divisor. One
// quotient bit per stage, rounds half away from zero, saturates to Q4.28.
// ----------------------------------------------------------------------------
module rpu_div
  import rpu_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic signed [63:0] num_x_i,
  input  logic signed [63:0] num_y_i,
  input  logic signed [31:0] den_x_i,
  input  logic signed [31:0] den_y_i,
  input  rpu_side_t          side_i,
  output logic               valid_o,
  output logic signed [31:0] q_x_o,
  output logic signed [31:0] q_y_o,
  output rpu_side_t          side_o
);

  logic [63:0] rem_x_q [0:RPU_QBITS];
  logic [63:0] rem_y_q [0:RPU_QBITS];
  logic [31:0] qx_q    [0:RPU_QBITS];
  logic [31:0] qy_q    [0:RPU_QBITS];
  logic [31:0] adx_q   [0:RPU_QBITS];
  logic [31:0] ady_q   [0:RPU_QBITS];
  logic        negx_q  [0:RPU_QBITS];
  logic        negy_q  [0:RPU_QBITS];
  logic        zx_q    [0:RPU_QBITS];
  logic        zy_q    [0:RPU_QBITS];
  rpu_side_t   side_q  [0:RPU_QBITS];
  logic        vld_q   [0:RPU_QBITS];

  logic [63:0] an_x, an_y;
  logic [31:0] ad_x, ad_y;

  assign an_x = num_x_i[63] ? 64'(-num_x_i) : 64'(num_x_i);
  assign an_y = num_y_i[63] ? 64'(-num_y_i) : 64'(num_y_i);
  assign ad_x = den_x_i[31] ? 32'(-den_x_i) : 32'(den_x_i);
  assign ad_y = den_y_i[31] ? 32'(-den_y_i) : 32'(den_y_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_x_q[0] <= an_x + 64'(ad_x >> 1);
      rem_y_q[0] <= an_y + 64'(ad_y >> 1);
      qx_q[0]    <= '0;
      qy_q[0]    <= '0;
      adx_q[0]   <= ad_x;
      ady_q[0]   <= ad_y;
      negx_q[0]  <= num_x_i[63] ^ den_x_i[31];
      negy_q[0]  <= num_y_i[63] ^ den_y_i[31];
      zx_q[0]    <= (an_x == '0);
      zy_q[0]    <= (an_y == '0);
      side_q[0]  <= side_i;
    end
  end

  for (genvar k = 1; k <= RPU_QBITS; k++) begin : g_bit
    localparam int B = RPU_QBITS - k;
    logic [63:0] dvs_x, dvs_y;
    logic        ge_x, ge_y;

    assign dvs_x = {32'b0, adx_q[k-1]} << B;
    assign dvs_y = {32'b0, ady_q[k-1]} << B;
    assign ge_x  = rem_x_q[k-1] >= dvs_x;
    assign ge_y  = rem_y_q[k-1] >= dvs_y;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_x_q[k] <= ge_x ? rem_x_q[k-1] - dvs_x : rem_x_q[k-1];
        rem_y_q[k] <= ge_y ? rem_y_q[k-1] - dvs_y : rem_y_q[k-1];
        qx_q[k]    <= qx_q[k-1] | ({31'b0, ge_x} << B);
        qy_q[k]    <= qy_q[k-1] | ({31'b0, ge_y} << B);
        adx_q[k]   <= adx_q[k-1];
        ady_q[k]   <= ady_q[k-1];
        negx_q[k]  <= negx_q[k-1];
        negy_q[k]  <= negy_q[k-1];
        zx_q[k]    <= zx_q[k-1];
        zy_q[k]    <= zy_q[k-1];
        side_q[k]  <= side_q[k-1];
      end
    end
  end

  // top quotient bit set means the quotient does not fit: saturate
  logic signed [31:0] mag_x, mag_y, res_x, res_y;
  logic signed [31:0] qx_o_q, qy_o_q;
  rpu_side_t          side_o_q;
  logic               vld_o_q;

  assign mag_x = $signed({1'b0, qx_q[RPU_QBITS][30:0]});
  assign mag_y = $signed({1'b0, qy_q[RPU_QBITS][30:0]});

  always_comb begin
    if (zx_q[RPU_QBITS]) res_x = '0;
    else if (qx_q[RPU_QBITS][31]) res_x = negx_q[RPU_QBITS] ? Q_MIN : Q_MAX;
    else res_x = negx_q[RPU_QBITS] ? -mag_x : mag_x;
    if (zy_q[RPU_QBITS]) res_y = '0;
    else if (qy_q[RPU_QBITS][31]) res_y = negy_q[RPU_QBITS] ? Q_MIN : Q_MAX;
    else res_y = negy_q[RPU_QBITS] ? -mag_y : mag_y;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_o_q <= 1'b0;
    end else if (en_i) begin
      vld_o_q <= vld_q[RPU_QBITS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      qx_o_q   <= res_x;
      qy_o_q   <= res_y;
      side_o_q <= side_q[RPU_QBITS];
    end
  end

  assign valid_o = vld_o_q;
  assign q_x_o   = qx_o_q;
  assign q_y_o   = qy_o_q;
  assign side_o  = side_o_q;

endmodule

FILE: rtl/rpu_cell.sv
// ----------------------------------------------------------------------------
// rpu_cell
// One refinement step: r2, radial factor, early-stop check, then divide
// the normalized point by the factor.
// ----------------------------------------------------------------------------
module rpu_cell
  import rpu_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic signed [23:0] k1_i,
  input  logic signed [23:0] k2_i,
  input  logic               valid_i,
  input  rpu_side_t          side_i,
  output logic               valid_o,
  output rpu_side_t          side_o
);

  rpu_side_t side_q [0:5];
  logic      vld_q  [0:5];

  logic [31:0]        ax, ay;
  logic [63:0]        sqx_q, sqy_q, sq;
  logic [35:0]        r2u;
  logic signed [31:0] r2_q, r2_b_q, r2_c_q, inner_q, rad_q;
  logic signed [55:0] p_q, p_rnd;
  logic signed [63:0] p2_q, p2_rnd;
  logic signed [39:0] inner_sum, rad_sum;
  logic signed [31:0] rad_d;
  logic               rad_tiny;
  rpu_side_t          side5_d;

  assign ax = side_i.x[31] ? 32'(-side_i.x) : 32'(side_i.x);
  assign ay = side_i.y[31] ? 32'(-side_i.y) : 32'(side_i.y);

  assign sq  = sqx_q + sqy_q;
  assign r2u = 36'((sq + 64'd134217728) >> 28);

  assign p_rnd     = (p_q + 56'sd524288) >>> 20;
  assign inner_sum = 40'($signed(p_rnd[35:0])) + (40'(k1_i) <<< 8);

  assign p2_rnd   = (p2_q + 64'sd134217728) >>> 28;
  assign rad_sum  = 40'($signed(p2_rnd[37:0])) + Q_ONE;
  assign rad_d    = rpu_sat32(rad_sum);
  assign rad_tiny = (rad_d > -RAD_EPS) && (rad_d < RAD_EPS);

  always_comb begin
    side5_d      = side_q[4];
    side5_d.done = side_q[4].done | rad_tiny;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) vld_q[i] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
      for (int i = 1; i < 6; i++) vld_q[i] <= vld_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sqx_q     <= 64'(ax) * 64'(ax);
      sqy_q     <= 64'(ay) * 64'(ay);
      side_q[0] <= side_i;
      r2_q      <= (r2u > 36'h07fff_ffff) ? Q_MAX : $signed({1'b0, r2u[30:0]});
      side_q[1] <= side_q[0];
      p_q       <= 56'(r2_q) * 56'(k2_i);
      r2_b_q    <= r2_q;
      side_q[2] <= side_q[1];
      inner_q   <= rpu_sat32(inner_sum);
      r2_c_q    <= r2_b_q;
      side_q[3] <= side_q[2];
      p2_q      <= 64'(r2_c_q) * 64'(inner_q);
      side_q[4] <= side_q[3];
      rad_q     <= rad_d;
      side_q[5] <= side5_d;
    end
  end

  logic signed [31:0] qx, qy;
  rpu_side_t          dside;

  rpu_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_i),
    .valid_i (vld_q[5]),
    .num_x_i (64'(side_q[5].xn) <<< 28),
    .num_y_i (64'(side_q[5].yn) <<< 28),
    .den_x_i (rad_q),
    .den_y_i (rad_q),
    .side_i  (side_q[5]),
    .valid_o (valid_o),
    .q_x_o   (qx),
    .q_y_o   (qy),
    .side_o  (dside)
  );

  always_comb begin
    side_o = dside;
    if (!dside.done) begin
      side_o.x = qx;
      side_o.y = qy;
    end
  end

endmodule

FILE: rtl/radial_point_undistort_core.sv
// ----------------------------------------------------------------------------
// radial_point_undistort_core
// Removes two-term radial lens distortion from a stream of pixel points.
// ----------------------------------------------------------------------------
// Takes one point word per cycle and returns one undistorted point word per
// point, in order. It has one input stage, a 34-stage normalizing divider,
// 20 refinement cells of 40 stages each (a 6-stage radial factor followed
// by a 34-stage bit-per-stage divider), and two output stages. The whole
// pipeline stalls as one while the output word waits. Registers may be
// written only while the pipeline is empty.
module radial_point_undistort_core
  import rpu_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [23:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // dist_u[21:0], dist_v[43:22], zero pad
  input  logic        s_axis_tlast,   // last_point
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // clean_u[21:0], clean_v[43:22], zero pad
  output logic        m_axis_tlast    // batch_end
);

  logic [23:0]        focal_x_q, focal_y_q;
  logic signed [21:0] center_x_q, center_y_q;
  logic signed [23:0] k1_q, k2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      focal_x_q  <= 24'd262144;
      focal_y_q  <= 24'd262144;
      center_x_q <= 22'sd163840;
      center_y_q <= 22'sd122880;
      k1_q       <= '0;
      k2_q       <= '0;
    end else if (cfg_we_i) begin
      case (rpu_reg_e'(cfg_idx_i))
        REG_FOCAL_X:  focal_x_q  <= cfg_data_i;
        REG_FOCAL_Y:  focal_y_q  <= cfg_data_i;
        REG_CENTER_X: center_x_q <= cfg_data_i[21:0];
        REG_CENTER_Y: center_y_q <= cfg_data_i[21:0];
        REG_K1:       k1_q       <= cfg_data_i;
        REG_K2:       k2_q       <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic en;
  logic out_vld_q;
  assign en            = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  // input stage: offset from principal point
  logic signed [22:0] du_q, dv_q;
  logic               in_vld_q;
  logic               in_last_q;
  rpu_side_t          in_side;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (en) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      du_q      <= 23'($signed(s_axis_tdata[21:0])) - 23'(center_x_q);
      dv_q      <= 23'($signed(s_axis_tdata[43:22])) - 23'(center_y_q);
      in_last_q <= s_axis_tlast;
    end
  end

  always_comb begin
    in_side      = '0;
    in_side.last = in_last_q;
  end

  logic               norm_vld;
  logic signed [31:0] norm_x, norm_y;
  rpu_side_t          norm_side;
  logic               cell_vld  [0:RPU_ITERS];
  rpu_side_t          cell_side [0:RPU_ITERS];

  rpu_div u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_vld_q),
    .num_x_i (64'(du_q) <<< 28),
    .num_y_i (64'(dv_q) <<< 28),
    .den_x_i ($signed({8'b0, focal_x_q})),
    .den_y_i ($signed({8'b0, focal_y_q})),
    .side_i  (in_side),
    .valid_o (norm_vld),
    .q_x_o   (norm_x),
    .q_y_o   (norm_y),
    .side_o  (norm_side)
  );

  always_comb begin
    cell_vld[0]  = norm_vld;
    cell_side[0] = norm_side;
    cell_side[0].xn = norm_x;
    cell_side[0].x  = norm_x;
    cell_side[0].yn = norm_y;
    cell_side[0].y  = norm_y;
  end

  for (genvar i = 0; i < RPU_ITERS; i++) begin : g_cell
    rpu_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .k1_i    (k1_q),
      .k2_i    (k2_q),
      .valid_i (cell_vld[i]),
      .side_i  (cell_side[i]),
      .valid_o (cell_vld[i+1]),
      .side_o  (cell_side[i+1])
    );
  end

  // back to pixels
  logic signed [56:0] pu_q, pv_q, pu_rnd, pv_rnd;
  logic               pix_vld_q, pix_last_q;
  logic signed [31:0] su, sv;
  logic [21:0]        out_u_q, out_v_q;
  logic               out_last_q;

  assign pu_rnd = (pu_q + 57'sd134217728) >>> 28;
  assign pv_rnd = (pv_q + 57'sd134217728) >>> 28;
  assign su     = 32'($signed(pu_rnd[28:0])) + 32'(center_x_q);
  assign sv     = 32'($signed(pv_rnd[28:0])) + 32'(center_y_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      pix_vld_q <= cell_vld[RPU_ITERS];
      out_vld_q <= pix_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pu_q       <= $signed({33'b0, focal_x_q}) * 57'(cell_side[RPU_ITERS].x);
      pv_q       <= $signed({33'b0, focal_y_q}) * 57'(cell_side[RPU_ITERS].y);
      pix_last_q <= cell_side[RPU_ITERS].last;
      out_u_q    <= (su > PIX_MAX) ? PIX_MAX[21:0] : (su < PIX_MIN) ? PIX_MIN[21:0] : su[21:0];
      out_v_q    <= (sv > PIX_MAX) ? PIX_MAX[21:0] : (sv < PIX_MIN) ? PIX_MIN[21:0] : sv[21:0];
      out_last_q <= pix_last_q;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {4'b0, out_v_q, out_u_q};
  assign m_axis_tlast  = out_last_q;

`ifndef SYNTHESIS
  a_no_accept_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tvalid && s_axis_tready && m_axis_tvalid && !m_axis_tready))
    else $error("word accepted while output stalled");

  a_norm_not_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    norm_vld |-> !norm_side.done)
    else $error("normalized word flagged done");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
    else $error("output word changed while stalled");
`endif

endmodule

FILE: bench/radial_point_undistort_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// radial_point_undistort_checker
// Watches both streams, predicts each undistorted point from the register
// values and compares it, field by field, with the word the core returns.
// ----------------------------------------------------------------------------
module radial_point_undistort_checker
  import rpu_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [23:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,
  input  logic        s_axis_tlast,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [47:0] m_axis_tdata,
  input  logic        m_axis_tlast,
  output int          errors_o,
  output int          pending_o,
  output int          seen_o
);

  typedef struct packed {
    logic        last;
    logic [21:0] v;
    logic [21:0] u;
  } point_t;

  logic [23:0] fx_r, fy_r, k1_r, k2_r;
  logic [21:0] cx_r, cy_r;
  point_t      clean_q[$];

  localparam longint QMX = 64'sd2147483647;
  localparam longint QMN = -64'sd2147483648;
  localparam longint QONE = 64'sd268435456;

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // floor((v + 2^(s-1)) / 2^s)
  function automatic longint round_shr(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint round_div(longint num, longint den);
    longint an, ad, q;
    if (den == 0) return num > 0 ? QMX : (num < 0 ? QMN : 0);
    an = num < 0 ? -num : num;
    ad = den < 0 ? -den : den;
    q = (an + ad / 2) / ad;
    if (q > QMX) return ((num < 0) != (den < 0)) ? QMN : QMX;
    return ((num < 0) != (den < 0)) ? -q : q;
  endfunction

  function automatic point_t undistort(logic [21:0] du, logic [21:0] dv, logic lst);
    longint fx, fy, cx, cy, k1, k2, xn, yn, x, y, r2, inner, rad;
    logic [63:0] ax, ay, sq, r2u;
    point_t p;
    fx = longint'(fx_r); fy = longint'(fy_r);
    cx = longint'($signed(cx_r)); cy = longint'($signed(cy_r));
    k1 = longint'($signed(k1_r)); k2 = longint'($signed(k2_r));
    xn = round_div((longint'($signed(du)) - cx) * QONE, fx);
    yn = round_div((longint'($signed(dv)) - cy) * QONE, fy);
    x = xn; y = yn;
    for (int i = 0; i < RPU_ITERS; i++) begin
      ax = x < 0 ? -x : x;
      ay = y < 0 ? -y : y;
      sq = ax * ax + ay * ay;
      r2u = (sq + (64'd1 << 27)) >> 28;
      r2 = r2u > QMX ? QMX : longint'(r2u);
      inner = clip(k1 * 256 + round_shr(r2 * k2, 20), QMN, QMX);
      rad = clip(QONE + round_shr(r2 * inner, 28), QMN, QMX);
      if (rad > -256 && rad < 256) break;
      x = round_div(xn * QONE, rad);
      y = round_div(yn * QONE, rad);
    end
    p.u = 22'(clip(round_shr(fx * x, 28) + cx, -64'sd2097152, 64'sd2097151));
    p.v = 22'(clip(round_shr(fy * y, 28) + cy, -64'sd2097152, 64'sd2097151));
    p.last = lst;
    return p;
  endfunction

  assign pending_o = clean_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    point_t e;
    if (!rst_ni) begin
      fx_r <= 24'd262144; fy_r <= 24'd262144;
      cx_r <= 22'd163840; cy_r <= 22'd122880;
      k1_r <= '0; k2_r <= '0;
      errors_o <= 0;
      seen_o <= 0;
      clean_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (rpu_reg_e'(cfg_idx_i))
          REG_FOCAL_X:  fx_r <= cfg_data_i;
          REG_FOCAL_Y:  fy_r <= cfg_data_i;
          REG_CENTER_X: cx_r <= cfg_data_i[21:0];
          REG_CENTER_Y: cy_r <= cfg_data_i[21:0];
          REG_K1:       k1_r <= cfg_data_i;
          REG_K2:       k2_r <= cfg_data_i;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready)
        clean_q.push_back(undistort(s_axis_tdata[21:0], s_axis_tdata[43:22],
                                    s_axis_tlast));
      if (m_axis_tvalid && m_axis_tready) begin
        seen_o <= seen_o + 1;
        if (clean_q.size() == 0) begin
          $display("%0t: unexpected word u=%h v=%h", $time, m_axis_tdata[21:0],
                   m_axis_tdata[43:22]);
          errors_o <= errors_o + 1;
        end else begin
          e = clean_q.pop_front();
          if (m_axis_tdata[21:0] !== e.u || m_axis_tdata[43:22] !== e.v ||
              m_axis_tlast !== e.last || m_axis_tdata[47:44] !== 4'd0) begin
            $display("%0t: mismatch expected u=%h v=%h last=%b, got u=%h v=%h last=%b pad=%h",
                     $time, e.u, e.v, e.last, m_axis_tdata[21:0], m_axis_tdata[43:22],
                     m_axis_tlast, m_axis_tdata[47:44]);
            errors_o <= errors_o + 1;
          end
        end
      end
    end
  end

endmodule

FILE: bench/tb_radial_point_undistort_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_radial_point_undistort_core
// Streams directed and random points through the core under several lens
// settings with random stalls on both sides; a checker compares every word.
// ----------------------------------------------------------------------------
module tb_radial_point_undistort_core
  import rpu_pkg::*;
;

  localparam int LAT = 837;
  localparam longint LIMIT = 3000000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [23:0] cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic        m_axis_tlast;
  int          errors, pending, seen;
  int          points;
  bit          calm;
  longint      cycles = 0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  radial_point_undistort_core DUT (.*);

  radial_point_undistort_checker chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
    .errors_o(errors), .pending_o(pending), .seen_o(seen)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    m_axis_tready <= calm || ($urandom_range(99) >= 6);
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles, %0d words pending", cycles, pending);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic write_reg(rpu_reg_e idx, logic [23:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    while (pending != 0) @(posedge clk_i);
    repeat (LAT + 10) @(posedge clk_i);
  endtask

  task automatic send_point(logic [21:0] u, logic [21:0] v, logic lst);
    while (!calm && $urandom_range(99) < 6) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {4'd0, v, u};
    s_axis_tlast <= lst;
    do @(posedge clk_i); while (!s_axis_tready);
    points++;
  endtask

  task automatic lens(logic [23:0] fx, logic [23:0] fy, logic [21:0] cx,
                      logic [21:0] cy, logic [23:0] k1, logic [23:0] k2);
    s_axis_tvalid <= 1'b0;
    drain();
    write_reg(REG_FOCAL_X, fx);
    write_reg(REG_FOCAL_Y, fy);
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_CENTER_Y, cy);
    write_reg(REG_K1, k1);
    write_reg(REG_K2, k2);
    write_reg(rpu_reg_e'(3'd7), 24'hffffff);
  endtask

  task automatic random_points(int n, int mode);
    logic [21:0] u, v;
    for (int i = 0; i < n; i++) begin
      case (mode)
        0: begin
          u = 22'($urandom_range(0, 1280 * 256));
          v = 22'($urandom_range(0, 960 * 256));
        end
        default: begin
          u = 22'($urandom);
          v = 22'($urandom);
        end
      endcase
      send_point(u, v, ($urandom_range(15) == 0));
    end
  endtask

  initial begin
    points = 0;
    calm = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: field extremes with reset lens
    send_point(22'h1fffff, 22'h200000, 1'b0);
    send_point(22'h200000, 22'h1fffff, 1'b1);
    send_point(22'd163840, 22'd122880, 1'b0);
    send_point(22'h3fffff, 22'h000000, 1'b1);
    send_point(22'h155555, 22'h2aaaaa, 1'b0);
    send_point(22'h2aaaaa, 22'h155555, 1'b1);

    // strong barrel, rad may cross zero
    lens(24'd262144, 24'd256000, 22'd163840, 22'd122880, 24'hf00000, 24'h7fffff);
    send_point(22'h1fffff, 22'h1fffff, 1'b0);
    send_point(22'd0, 22'd0, 1'b0);
    send_point(22'd300000, 22'd200000, 1'b1);
    send_point(22'd200000, 22'd140000, 1'b0);
    random_points(60, 1);

    // minimum focal, extreme coefficients and centers
    lens(24'd256, 24'd256, 22'h1fffff, 22'h200000, 24'h800000, 24'h800000);
    send_point(22'h200000, 22'h1fffff, 1'b1);
    send_point(22'h1fffff, 22'h200000, 1'b0);
    random_points(60, 1);

    lens(24'hffffff, 24'hffffff, 22'h200000, 22'h1fffff, 24'h7fffff, 24'h7fffff);
    random_points(60, 1);

    // mild realistic lens, long calm stretch then pressure pause
    lens(24'd262144 + 24'($urandom_range(0, 65535)), 24'd250000,
         22'd163840, 22'd122880, 24'hfc0000, 24'h020000);
    calm = 1'b1;
    random_points(300, 0);
    calm = 1'b0;
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    random_points(300, 0);

    for (int ph = 0; ph < 5; ph++) begin
      lens(24'($urandom_range(256, 1 << 20)), 24'($urandom_range(256, 1 << 20)),
           22'($urandom), 22'($urandom), 24'($urandom), 24'($urandom));
      random_points(180, ph % 2);
    end

    s_axis_tvalid <= 1'b0;
    drain();
    $display("Covered %0d points under 10 lens settings; %0d words checked.", points, seen);
    if (errors == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
